/* hw/rtl/lzwc_pkg.sv */
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the LZW byte compressor.
// ----------------------------------------------------------------------------
package lzwc_pkg;

	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int EOF_CODE    = 256;
	localparam int FIRST_FREE  = 257;
	localparam int START_WIDTH = 9;
	localparam int WIDTH_W     = 5;
	localparam int STAT_NFC_W  = 17;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [STAT_NFC_W-1:0] next_free;
		logic [WIDTH_W-1:0]    width;
	} status_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_HEAD = 7'b0000010,
		ST_WALK = 7'b0000100,
		ST_MISS = 7'b0001000,
		ST_INS  = 7'b0010000,
		ST_EOS  = 7'b0100000,
		ST_EOF  = 7'b1000000
	} state_t;

endpackage

/* hw/rtl/lzwc_ram.sv */
// ----------------------------------------------------------------------------
// lzwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* hw/rtl/lzwc_front.sv */
// ----------------------------------------------------------------------------
// lzwc_front
// Input side: accepts byte requests into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module lzwc_front
	import lzwc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       item_valid,
	output item_t      item,
	input  logic       item_pop
);
	item_t slot_q [2];
	logic  rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;
	logic  push;

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{data_byte: data_byte, end_of_stream: end_of_stream};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (item_pop && item_valid) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(item_pop && item_valid);
		end
	end
endmodule

/* hw/rtl/lzwc_engine.sv */
// ----------------------------------------------------------------------------
// lzwc_engine
// Match engine: walks the child/sibling trie, inserts entries, emits codes.
// ----------------------------------------------------------------------------
module lzwc_engine
	import lzwc_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] code_value,
	output logic [3:0]  code_bits,
	output logic        final_code,
	output status_t     status
);
	localparam int M    = MAX_CODE_BITS;
	localparam int DICT = 1 << M;

	state_t state_q;
	logic [M-1:0]       match_q, cur_q, head_q;
	logic               mv_q, eos_q;
	logic [7:0]         byte_q;
	logic [M:0]         nfc_q;
	logic [WIDTH_W-1:0] w_q;
	logic [255:0]       root_valid_q;

	logic               out_valid_q, fin_q;
	logic [11:0]        code_q;
	logic [3:0]         bits_q;

	logic               node_wr_en, node_rd_en, child_wr_en, child_rd_en;
	logic [M-1:0]       node_wr_addr, node_rd_addr, child_wr_addr, child_rd_addr;
	logic [M+7:0]       node_wr_data, node_rd_data;
	logic [M-1:0]       child_wr_data, child_rd_data;

	logic               can_load, out_load, is_root, item_root;
	logic [7:0]         walk_byte;
	logic [M-1:0]       walk_sib;
	logic [M:0]         nfc_inc, width_lim;

	lzwc_ram #(.WIDTH(M + 8), .DEPTH(DICT)) u_node_ram (
		.clk(clk), .wr_en(node_wr_en), .wr_addr(node_wr_addr), .wr_data(node_wr_data),
		.rd_en(node_rd_en), .rd_addr(node_rd_addr), .rd_data(node_rd_data)
	);

	lzwc_ram #(.WIDTH(M), .DEPTH(DICT)) u_child_ram (
		.clk(clk), .wr_en(child_wr_en), .wr_addr(child_wr_addr), .wr_data(child_wr_data),
		.rd_en(child_rd_en), .rd_addr(child_rd_addr), .rd_data(child_rd_data)
	);

	assign can_load  = !out_valid_q || !out_stall;
	assign out_load  = can_load && ((state_q == ST_MISS) || (state_q == ST_EOF) ||
		((state_q == ST_EOS) && eos_q));
	assign is_root   = (match_q[M-1:8] == '0);
	assign item_root = is_root && root_valid_q[match_q[7:0]];
	assign walk_byte = node_rd_data[M+7:M];
	assign walk_sib  = node_rd_data[M-1:0];
	assign nfc_inc   = nfc_q + (M+1)'(1);
	assign width_lim = (M+1)'(1) << w_q;
	assign item_pop  = (state_q == ST_IDLE) && item_valid;

	always_comb begin
		node_wr_en    = 1'b0;
		node_wr_addr  = nfc_q[M-1:0];
		node_wr_data  = {byte_q, head_q};
		node_rd_en    = 1'b0;
		node_rd_addr  = walk_sib;
		child_wr_en   = 1'b0;
		child_wr_addr = nfc_q[M-1:0];
		child_wr_data = '0;
		child_rd_en   = 1'b0;
		child_rd_addr = match_q;
		unique case (state_q)
			ST_IDLE: begin
				child_rd_en = item_valid && mv_q && (!is_root || item_root);
			end
			ST_HEAD: begin
				node_rd_en   = (child_rd_data != '0);
				node_rd_addr = child_rd_data;
			end
			ST_WALK: begin
				node_rd_en = (walk_byte != byte_q) && (walk_sib != '0);
			end
			ST_MISS: begin
				node_wr_en  = can_load && !nfc_q[M];
				child_wr_en = can_load && !nfc_q[M];
			end
			ST_INS: begin
				child_wr_en   = 1'b1;
				child_wr_addr = match_q;
				child_wr_data = nfc_q[M-1:0];
			end
			ST_EOS, ST_EOF: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			byte_q <= item.data_byte;
			eos_q  <= item.end_of_stream;
			head_q <= '0;
		end
		if (state_q == ST_HEAD) begin
			head_q <= child_rd_data;
			cur_q  <= child_rd_data;
		end
		if (state_q == ST_WALK) begin
			cur_q <= walk_sib;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			match_q      <= '0;
			mv_q         <= 1'b0;
			nfc_q        <= (M+1)'(FIRST_FREE);
			w_q          <= WIDTH_W'(START_WIDTH);
			root_valid_q <= '0;
			out_valid_q  <= 1'b0;
			code_q       <= '0;
			bits_q       <= '0;
			fin_q        <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (!mv_q) begin
							match_q <= M'(item.data_byte);
							mv_q    <= 1'b1;
							state_q <= ST_EOS;
						end else if (is_root && !item_root) begin
							state_q <= ST_MISS;
						end else begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					state_q <= (child_rd_data == '0) ? ST_MISS : ST_WALK;
				end
				ST_WALK: begin
					if (walk_byte == byte_q) begin
						match_q <= cur_q;
						state_q <= ST_EOS;
					end else if (walk_sib == '0) begin
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					if (can_load) begin
						code_q      <= 12'(match_q);
						bits_q      <= 4'(w_q);
						fin_q       <= 1'b0;
						if (!nfc_q[M]) begin
							state_q <= ST_INS;
						end else begin
							match_q <= M'(byte_q);
							state_q <= ST_EOS;
						end
					end
				end
				ST_INS: begin
					if (is_root) root_valid_q[match_q[7:0]] <= 1'b1;
					nfc_q <= nfc_inc;
					if (w_q < WIDTH_W'(M) && nfc_inc == width_lim) w_q <= w_q + WIDTH_W'(1);
					match_q <= M'(byte_q);
					state_q <= ST_EOS;
				end
				ST_EOS: begin
					if (!eos_q) begin
						state_q <= ST_IDLE;
					end else if (can_load) begin
						code_q      <= 12'(match_q);
						bits_q      <= 4'(w_q);
						fin_q       <= 1'b0;
						state_q     <= ST_EOF;
					end
				end
				ST_EOF: begin
					if (can_load) begin
						code_q       <= 12'(EOF_CODE);
						bits_q       <= 4'(w_q);
						fin_q        <= 1'b1;
						// drop the stream's dictionary and start over
						match_q      <= '0;
						mv_q         <= 1'b0;
						nfc_q        <= (M+1)'(FIRST_FREE);
						w_q          <= WIDTH_W'(START_WIDTH);
						root_valid_q <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign code_value = code_q;
	assign code_bits  = bits_q;
	assign final_code = fin_q;
	assign status     = '{next_free: STAT_NFC_W'(nfc_q), width: w_q};
endmodule

/* hw/rtl/lzw_byte_compressor_unit.sv */
// ----------------------------------------------------------------------------
// lzw_byte_compressor_unit
// LZW encoder producing variable-width codes from a byte stream.
// ----------------------------------------------------------------------------
// Passes: after the two-entry queue, a byte that starts a match visits ST_IDLE,
//   ST_EOS; a hit ST_IDLE, ST_HEAD, an ST_WALK step per trie node compared, ST_EOS;
//   a miss also ST_MISS, then ST_INS unless the dictionary is full, and ST_EOS;
//   end of stream adds ST_EOF, and a stalled result holds the engine.
// Throughput: one byte per engine pass above, set by the serial trie walk on
//   the node RAM read port. Reset: arst_n clears queue, engine state and
//   first-level valid bits; RAMs are not cleared.
module lzw_byte_compressor_unit
	import lzwc_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] code_value,
	output logic [3:0]  code_bits,
	output logic        final_code
);
	logic    item_valid, item_pop;
	item_t   item;
	status_t status;

	lzwc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_stream(end_of_stream),
		.item_valid(item_valid), .item(item), .item_pop(item_pop)
	);

	lzwc_engine #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item(item),
		.item_pop(item_pop), .out_valid(out_valid), .out_stall(out_stall),
		.code_value(code_value), .code_bits(code_bits), .final_code(final_code),
		.status(status)
	);

	a_final_is_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_code |-> code_value == 12'(EOF_CODE))
		else $error("final code is not the EOF code");

	a_nfc_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.next_free <= STAT_NFC_W'(1 << MAX_CODE_BITS)
		&& status.next_free >= STAT_NFC_W'(FIRST_FREE))
		else $error("next free code out of range");

	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.width <= WIDTH_W'(MAX_CODE_BITS) && status.width >= WIDTH_W'(START_WIDTH))
		else $error("code width out of range");
endmodule

/* tb/sv/lzw_byte_compressor_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_byte_compressor_unit_tb
// Drives byte streams into the LZW compressor and checks every emitted code,
// width and end mark against a behavioral encoder kept in the testbench.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_unit_tb;
	import lzwc_pkg::*;

	localparam int MCB       = MAX_CODE_BITS_DEF;
	localparam int DICT_SIZE = 1 << MCB;
	localparam int WD_LIMIT  = 20000;

	typedef struct packed {
		logic [11:0] code;
		logic [3:0]  bits;
		logic        fin;
	} code_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_stream;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] code_value;
	logic [3:0]  code_bits;
	logic        final_code;

	item_t pending_q[$];
	code_t expected_codes[$];

	// encoder state
	int unsigned cur_match;
	bit          have_match;
	int unsigned free_code;
	int unsigned cur_width;
	int unsigned dict[DICT_SIZE];

	bit          failed;
	bit          stim_done;
	bit          hold_req;
	bit          hold_used;
	int          hold_cnt;
	bit          pause_req;
	int          in_gap;
	int          out_gap;
	int          idle_cycles;

	lzw_byte_compressor_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_stream(end_of_stream),
		.out_valid(out_valid), .out_stall(out_stall),
		.code_value(code_value), .code_bits(code_bits), .final_code(final_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_code(int unsigned c, int unsigned w, bit f);
		code_t e;
		e.code = c[11:0];
		e.bits = w[3:0];
		e.fin  = f;
		expected_codes.insert(expected_codes.size(), e);
	endfunction

	function automatic void add_item(item_t it);
		pending_q.insert(pending_q.size(), it);
	endfunction

	function automatic void encode_byte(item_t it);
		int unsigned key;
		int unsigned hit;
		hit = 0;
		if (!have_match) begin
			cur_match  = it.data_byte;
			have_match = 1'b1;
		end else begin
			key = (cur_match << 8) | it.data_byte;
			for (int unsigned k = FIRST_FREE; k < free_code && k < DICT_SIZE; k++)
				if (hit == 0 && dict[k] == key) hit = k;
			if (hit != 0) begin
				cur_match = hit;
			end else begin
				push_code(cur_match, cur_width, 1'b0);
				if (free_code < DICT_SIZE) begin
					dict[free_code] = key;
					free_code++;
					if (cur_width < MCB && free_code == (1 << cur_width))
						cur_width++;
				end
				cur_match = it.data_byte;
			end
		end
		if (it.end_of_stream) begin
			push_code(cur_match, cur_width, 1'b0);
			push_code(EOF_CODE, cur_width, 1'b1);
			cur_match  = 0;
			have_match = 1'b0;
			free_code  = FIRST_FREE;
			cur_width  = START_WIDTH;
		end
	endfunction

	function automatic item_t mk(int unsigned b, bit e);
		item_t it;
		it.data_byte     = b[7:0];
		it.end_of_stream = e;
		return it;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			data_byte     <= '0;
			end_of_stream <= 1'b0;
			in_gap        <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) encode_byte(pending_q.pop_front());
			if (in_gap > 0 || pause_req || pending_q.size() == 0) begin
				in_valid <= 1'b0;
				if (in_gap > 0) in_gap <= in_gap - 1;
			end else begin
				in_valid      <= 1'b1;
				data_byte     <= pending_q[0].data_byte;
				end_of_stream <= pending_q[0].end_of_stream;
				in_gap        <= $urandom_range(0, 4) * ($urandom_range(0, 3) != 0);
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt  <= 0;
			hold_used <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_cnt  <= 60;
			hold_used <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		code_t e;
		if (!arst_n) begin
			out_stall <= 1'b1;
			out_gap   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected code %0d", code_value);
					failed = 1'b1;
				end else begin
					e = expected_codes.pop_front();
					if (code_value !== e.code) begin
						$error("code_value exp %0d got %0d", e.code, code_value);
						failed = 1'b1;
					end
					if (code_bits !== e.bits) begin
						$error("code_bits exp %0d got %0d", e.bits, code_bits);
						failed = 1'b1;
					end
					if (final_code !== e.fin) begin
						$error("final_code exp %0d got %0d", e.fin, final_code);
						failed = 1'b1;
					end
				end
			end
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap   <= out_gap - 1;
			end else begin
				out_stall <= 1'b0;
				if (out_valid && !out_stall)
					out_gap <= $urandom_range(0, 4) * ($urandom_range(0, 2) != 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				hold_cnt > 0)
			idle_cycles <= 0;
		else if (pending_q.size() != 0 || expected_codes.size() != 0 || !stim_done)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int n;
		int len;
		int alpha;
		stim_done  = 1'b0;
		pause_req  = 1'b0;
		hold_req   = 1'b0;
		have_match = 1'b0;
		cur_match  = 0;
		free_code  = FIRST_FREE;
		cur_width  = START_WIDTH;
		arst_n     = 1'b0;
		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed: single-byte stream, extremes, repeats building matches
		add_item(mk(8'h00, 1'b1));
		add_item(mk(8'hFF, 1'b1));
		for (int i = 0; i < 8; i++) add_item(mk(8'hAA, 1'b0));
		add_item(mk(8'h55, 1'b1));
		for (int i = 0; i < 6; i++) add_item(mk(i % 2 ? 8'hFF : 8'h00, i == 5));

		// long hold-off with the sender still offering
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) add_item(mk(i % 3, i == 11));
		wait (pending_q.size() == 0);

		// hold the sender until every expected code has come out
		pause_req = 1'b1;
		for (int i = 0; i < 120; i++) add_item(mk($urandom_range(0, 255), i == 119));
		wait (!in_valid && expected_codes.size() == 0 && hold_cnt == 0);
		repeat (10) @(posedge clk);
		pause_req = 1'b0;

		// random streams
		n = 0;
		while (n < 60) begin
			len   = $urandom_range(1, 30);
			alpha = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 4);
			for (int i = 0; i < len; i++)
				add_item(mk($urandom_range(0, alpha), i == len - 1));
			n += len;
		end
		wait (pending_q.size() == 0 && !in_valid && expected_codes.size() == 0);
		repeat (50) @(posedge clk);
		stim_done = 1'b1;
		if (!failed && expected_codes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
